[hw/rtl/dotted_version_parser_unit_assert.svh]
// Assertion macros for the checker file dvp_checker.sv.
`ifndef DOTTED_VERSION_PARSER_UNIT_ASSERT_SVH
`define DOTTED_VERSION_PARSER_UNIT_ASSERT_SVH

// Checked on every rising edge of clk outside reset.
`define DVP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DVP_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dvp_pkg.sv]
package dvp_pkg;

	localparam int DEF_MAX_COMPONENTS = 4;
	localparam int NUM_PARTS = 4;
	localparam int PART_W = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PART_W-1:0] VALUE_LIMIT = 31'h7FFF_FFFF;

	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_MANY = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_NONDIGIT = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [7:0] character;
		logic end_marker;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [PART_W-1:0] major_part;
		logic [PART_W-1:0] minor_part;
		logic [PART_W-1:0] patch_part;
		logic [PART_W-1:0] tweak_part;
	} result_t;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_DOT = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_END = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] digit;
	} cls_t;

	// read side of the queue as seen by the back end
	typedef struct packed {
		logic avail;
		cls_t entry;
	} q_rd_t;

endpackage

[hw/rtl/dvp_front.sv]
module dvp_front
	import dvp_pkg::*;
(
	input logic item_valid,
	input in_item_t item,
	input logic q_full,
	output logic item_stall,
	output logic push,
	output cls_t cls
);

	logic [7:0] offs;

	assign item_stall = q_full;
	assign push = item_valid && !q_full;
	assign offs = item.character - CHAR_ZERO;

	always_comb begin
		cls.digit = offs[3:0];
		if (item.end_marker) begin
			cls.kind = KIND_END;
		end else if (item.character == CHAR_DOT) begin
			cls.kind = KIND_DOT;
		end else if (item.character >= CHAR_ZERO && item.character <= CHAR_NINE) begin
			cls.kind = KIND_DIGIT;
		end else begin
			cls.kind = KIND_OTHER;
		end
	end

endmodule

[hw/rtl/dvp_fifo.sv]
module dvp_fifo
	import dvp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input cls_t wr_data,
	input logic pop,
	output logic full,
	output q_rd_t rd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cls_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(QUEUE_DEPTH);
	assign rd.avail = count_q != '0;
	assign rd.entry = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		if (32'(p) == QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/dvp_back.sv]
module dvp_back
	import dvp_pkg::*;
#(
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
	input logic clk,
	input logic arst_n,
	input q_rd_t rd,
	output logic pop,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	localparam int IDX_W = $clog2(MAX_COMPONENTS + 1);

	logic [IDX_W-1:0] idx_q, n_idx;
	logic [PART_W-1:0] acc_q, n_acc;
	logic nonempty_q, n_nonempty;
	logic nondigit_q, n_nondigit;
	logic overflow_q, n_overflow;
	logic [2:0] sticky_q, n_sticky;
	logic [PART_W-1:0] vals_q [NUM_PARTS];
	logic [PART_W-1:0] n_vals [NUM_PARTS];

	logic out_free;
	logic load_result;
	result_t res_d;
	logic [PART_W+3:0] acc_next;
	logic [2:0] close_err;
	logic [PART_W-1:0] parts [NUM_PARTS];

	assign out_free = !result_valid || !result_stall;
	// an end item may leave the queue only when the output register can take it
	assign pop = rd.avail && (rd.entry.kind != KIND_END || out_free);
	assign load_result = pop && rd.entry.kind == KIND_END;

	// acc * 10 + digit
	assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {(PART_W)'(0), rd.entry.digit};

	always_comb begin
		if (!nonempty_q) begin
			close_err = ST_EMPTY;
		end else if (nondigit_q) begin
			close_err = ST_NONDIGIT;
		end else if (overflow_q) begin
			close_err = ST_OVERFLOW;
		end else if (32'(idx_q) < MAX_COMPONENTS) begin
			close_err = ST_OK;
		end else begin
			close_err = ST_TOO_MANY;
		end
	end

	always_comb begin
		n_idx = idx_q;
		n_acc = acc_q;
		n_nonempty = nonempty_q;
		n_nondigit = nondigit_q;
		n_overflow = overflow_q;
		n_sticky = sticky_q;
		for (int k = 0; k < NUM_PARTS; k++) begin
			n_vals[k] = vals_q[k];
		end

		if (pop && sticky_q == ST_OK) begin
			unique case (rd.entry.kind)
				KIND_DOT, KIND_END: begin
					n_sticky = close_err;
					if (close_err == ST_OK) begin
						for (int k = 0; k < NUM_PARTS; k++) begin
							if (32'(idx_q) == k) begin
								n_vals[k] = acc_q;
							end
						end
						n_idx = idx_q + 1'b1;
						if (rd.entry.kind == KIND_DOT && 32'(n_idx) >= MAX_COMPONENTS) begin
							n_sticky = ST_TOO_MANY;
						end
					end
					n_acc = '0;
					n_nonempty = 1'b0;
					n_nondigit = 1'b0;
					n_overflow = 1'b0;
				end
				KIND_DIGIT: begin
					n_nonempty = 1'b1;
					if (!overflow_q) begin
						if (acc_next > {4'b0, VALUE_LIMIT}) begin
							n_overflow = 1'b1;
						end else begin
							n_acc = acc_next[PART_W-1:0];
						end
					end
				end
				KIND_OTHER: begin
					n_nonempty = 1'b1;
					n_nondigit = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_PARTS; k++) begin
			parts[k] = (n_sticky == ST_OK && k < 32'(n_idx)) ? n_vals[k] : '0;
		end
		res_d.status = n_sticky;
		res_d.major_part = parts[0];
		res_d.minor_part = parts[1];
		res_d.patch_part = parts[2];
		res_d.tweak_part = parts[3];
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_PARTS; k++) begin
			vals_q[k] <= n_vals[k];
		end
		if (load_result) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
			nonempty_q <= 1'b0;
			nondigit_q <= 1'b0;
			overflow_q <= 1'b0;
			sticky_q <= ST_OK;
			result_valid <= 1'b0;
		end else begin
			if (load_result) begin
				// string done: back to the empty state
				idx_q <= '0;
				acc_q <= '0;
				nonempty_q <= 1'b0;
				nondigit_q <= 1'b0;
				overflow_q <= 1'b0;
				sticky_q <= ST_OK;
				result_valid <= 1'b1;
			end else begin
				idx_q <= n_idx;
				acc_q <= n_acc;
				nonempty_q <= n_nonempty;
				nondigit_q <= n_nondigit;
				overflow_q <= n_overflow;
				sticky_q <= n_sticky;
				if (!result_stall) begin
					result_valid <= 1'b0;
				end
			end
		end
	end

endmodule

[hw/rtl/dotted_version_parser_unit.sv]
// Dotted decimal version parser.
// Throughput: one item per cycle, end items included, while result_stall is low.
// Path: an accepted end item is written into the queue, then the parse step pops it, once the output
// register can take it, and loads the output register, which raises result_valid.
// Reset: arst_n clears the queue, the parse state and result_valid at once.
module dotted_version_parser_unit
	import dvp_pkg::*;
#(
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	logic push;
	logic pop;
	logic q_full;
	cls_t cls;
	q_rd_t rd;

	dvp_front u_front (
		.item_valid(item_valid),
		.item(item),
		.q_full(q_full),
		.item_stall(item_stall),
		.push(push),
		.cls(cls)
	);

	dvp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(cls),
		.pop(pop),
		.full(q_full),
		.rd(rd)
	);

	dvp_back #(
		.MAX_COMPONENTS(MAX_COMPONENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd(rd),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

[hw/rtl/dvp_checker.sv]
`include "dotted_version_parser_unit_assert.svh"

module dvp_checker
	import dvp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input in_item_t item,
	input logic result_valid,
	input logic result_stall,
	input result_t result
);

	`DVP_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
	`DVP_ASSERT(a_err_zero, result_valid && result.status != ST_OK |-> result.major_part == '0 && result.minor_part == '0 && result.patch_part == '0 && result.tweak_part == '0, "error result carries values")
	`DVP_ASSERT(a_status_range, result_valid |-> result.status <= ST_OVERFLOW, "status code out of range")
	`DVP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result_valid && !item_stall, "outputs active in reset")

endmodule

bind dotted_version_parser_unit dvp_checker u_dvp_checker (.*);

[dv/tb.sv]
module tb;
	import dvp_pkg::*;

	localparam int MAX_COMP = DEF_MAX_COMPONENTS;

	typedef struct {
		string text;
		logic [7:0] end_char;
		bit typed;
		result_t want;
	} version_case_t;

	logic clk;
	logic arst_n;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int item_count = 0;
	int mismatches = 0;

	result_t pending_results[$];
	result_t oldest_result;
	logic [7:0] text_q[$];

	// parser state kept by the predictor
	int pr_index;
	logic [PART_W-1:0] pr_acc;
	bit pr_nonempty;
	bit pr_nondigit;
	bit pr_overflow;
	logic [2:0] pr_sticky;
	logic [PART_W-1:0] pr_values [MAX_COMP];

	// typed expectations only where they are obvious; the rest come from the predictor
	version_case_t directed_cases [15] = '{
		'{"", 8'h00, 1'b1, '{ST_EMPTY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"2147483647", 8'hFF, 1'b1, '{ST_OK, VALUE_LIMIT, 31'd0, 31'd0, 31'd0}},
		'{"2147483648", 8'h00, 1'b1, '{ST_OVERFLOW, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"1.2.3.4", 8'h00, 1'b0, '0},
		'{"007.10.2147483647", 8'h00, 1'b0, '0},
		'{"1.2.3.4.5", 8'h00, 1'b1, '{ST_TOO_MANY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"1.2.3.4.", 8'h00, 1'b1, '{ST_TOO_MANY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"1.2.", 8'h00, 1'b1, '{ST_EMPTY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{".1", 8'h00, 1'b1, '{ST_EMPTY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"1..x", 8'h00, 1'b1, '{ST_EMPTY, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"3.9a", 8'h00, 1'b1, '{ST_NONDIGIT, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"/:.0", 8'h00, 1'b1, '{ST_NONDIGIT, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"99999999999z", 8'h00, 1'b1, '{ST_NONDIGIT, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"5.99999999999.a", 8'h00, 1'b1, '{ST_OVERFLOW, 31'd0, 31'd0, 31'd0, 31'd0}},
		'{"42\377", 8'h2E, 1'b1, '{ST_NONDIGIT, 31'd0, 31'd0, 31'd0, 31'd0}}
	};

	dotted_version_parser_unit #(
		.MAX_COMPONENTS(MAX_COMP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	task report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task clear_segment();
		pr_acc = '0;
		pr_nonempty = 1'b0;
		pr_nondigit = 1'b0;
		pr_overflow = 1'b0;
	endtask

	task clear_parser();
		pr_index = 0;
		pr_sticky = ST_OK;
		clear_segment();
		for (int k = 0; k < MAX_COMP; k++) pr_values[k] = '0;
	endtask

	task close_component();
		if (pr_sticky == ST_OK) begin
			if (!pr_nonempty) begin
				pr_sticky = ST_EMPTY;
			end else if (pr_nondigit) begin
				pr_sticky = ST_NONDIGIT;
			end else if (pr_overflow) begin
				pr_sticky = ST_OVERFLOW;
			end else if (pr_index < MAX_COMP) begin
				pr_values[pr_index] = pr_acc;
				pr_index++;
			end else begin
				pr_sticky = ST_TOO_MANY;
			end
			clear_segment();
		end
	endtask

	task parse_version_item(input in_item_t it, output bit has_result, output result_t r);
		logic [63:0] next_acc;
		logic [PART_W-1:0] parts [NUM_PARTS];
		has_result = 1'b0;
		r = '0;
		if (!it.end_marker) begin
			if (pr_sticky == ST_OK) begin
				if (it.character == CHAR_DOT) begin
					close_component();
					// the dot that closes the last allowed component already means one too many
					if (pr_sticky == ST_OK && pr_index >= MAX_COMP) pr_sticky = ST_TOO_MANY;
				end else begin
					pr_nonempty = 1'b1;
					if (it.character < CHAR_ZERO || it.character > CHAR_NINE) begin
						pr_nondigit = 1'b1;
					end else if (!pr_overflow) begin
						next_acc = 64'(pr_acc) * 64'd10 + 64'(it.character - CHAR_ZERO);
						if (next_acc > 64'(VALUE_LIMIT)) pr_overflow = 1'b1;
						else pr_acc = next_acc[PART_W-1:0];
					end
				end
			end
		end else begin
			close_component();
			for (int k = 0; k < NUM_PARTS; k++) begin
				parts[k] = '0;
				if (pr_sticky == ST_OK && k < MAX_COMP && k < pr_index) parts[k] = pr_values[k];
			end
			r.status = pr_sticky;
			r.major_part = parts[0];
			r.minor_part = parts[1];
			r.patch_part = parts[2];
			r.tweak_part = parts[3];
			has_result = 1'b1;
			clear_parser();
		end
	endtask

	task send_version_item(input logic [7:0] ch, input logic endm, input bit typed,
			input result_t want);
		in_item_t it;
		bit has_result;
		result_t predicted;
		it = '{character: ch, end_marker: endm};
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		parse_version_item(it, has_result, predicted);
		if (has_result) pending_results.push_back(typed ? want : predicted);
		item_count++;
	endtask

	task send_text();
		for (int i = 0; i < text_q.size(); i++) send_version_item(text_q[i], 1'b0, 1'b0, '0);
		send_version_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
	endtask

	task push_digit();
		text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
	endtask

	// mostly well-formed versions with random values; some broken, some plain noise
	task build_random_text();
		int shape;
		int ncomp;
		int len_pick;
		int pos;
		string num;
		text_q.delete();
		shape = $urandom_range(99);
		if (shape < 85) begin
			ncomp = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
			for (int c = 0; c < ncomp; c++) begin
				if (c > 0) text_q.push_back(CHAR_DOT);
				len_pick = $urandom_range(99);
				if (len_pick < 85) begin
					repeat ($urandom_range(1, 3)) push_digit();
				end else if (len_pick < 93) begin
					// values straddling the limit
					num = $sformatf("%0d", 32'd2147483640 + 32'($urandom_range(15)));
					for (int j = 0; j < num.len(); j++) text_q.push_back(num[j]);
				end else begin
					repeat ($urandom_range(9, 12)) push_digit();
				end
			end
			if (shape >= 70) begin
				pos = $urandom_range(text_q.size() - 1);
				case ($urandom_range(3))
					0: text_q[pos] = 8'($urandom_range(255));
					1: text_q.insert(pos, CHAR_DOT);
					2: text_q.push_back(CHAR_DOT);
					default: text_q.push_front(CHAR_DOT);
				endcase
			end
		end else begin
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(2))
					0: push_digit();
					1: text_q.push_back(CHAR_DOT);
					default: text_q.push_back(8'($urandom_range(255)));
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < rx_stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d",
					result.status));
			end else begin
				oldest_result = pending_results.pop_front();
				if (result.status !== oldest_result.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						result.status, oldest_result.status));
				if (result.major_part !== oldest_result.major_part)
					report_mismatch($sformatf("major_part got %0d expected %0d",
						result.major_part, oldest_result.major_part));
				if (result.minor_part !== oldest_result.minor_part)
					report_mismatch($sformatf("minor_part got %0d expected %0d",
						result.minor_part, oldest_result.minor_part));
				if (result.patch_part !== oldest_result.patch_part)
					report_mismatch($sformatf("patch_part got %0d expected %0d",
						result.patch_part, oldest_result.patch_part));
				if (result.tweak_part !== oldest_result.tweak_part)
					report_mismatch($sformatf("tweak_part got %0d expected %0d",
						result.tweak_part, oldest_result.tweak_part));
			end
		end
	end

	initial begin
		int phase_start;
		int drain;
		arst_n <= 1'b0;
		clear_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 9;
					rx_stall_pct = 61;
				end
				1: begin
					tx_idle_pct = 61;
					rx_stall_pct = 9;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
			endcase
			if (phase == 0) begin
				for (int n = 0; n < $size(directed_cases); n++) begin
					for (int i = 0; i < directed_cases[n].text.len(); i++)
						send_version_item(directed_cases[n].text[i], 1'b0, 1'b0, '0);
					send_version_item(directed_cases[n].end_char, 1'b1,
						directed_cases[n].typed, directed_cases[n].want);
				end
			end
			phase_start = item_count;
			while (item_count < phase_start + 92) begin
				build_random_text();
				send_text();
			end
			// hold the sender until every pending result is out
			item_valid <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
		end

		drain = 0;
		while (pending_results.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dvp_pkg.sv
hw/rtl/dvp_front.sv
hw/rtl/dvp_fifo.sv
hw/rtl/dvp_back.sv
hw/rtl/dotted_version_parser_unit.sv
hw/rtl/dvp_checker.sv
dv/tb.sv
